// File: rtl/mspc_pkg.sv
package mspc_pkg;

  localparam int MOTOR_COUNT_DEF = 8;
  localparam int MASK_W          = 8;
  localparam int POS_W           = 16;
  localparam int TOL_W           = 8;
  localparam int ID_W            = 3;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;

  localparam logic [POS_W-1:0] UPPER_LIMIT_RESET = POS_W'(100);
  localparam logic [TOL_W-1:0] TOLERANCE_RESET   = TOL_W'(2);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'b1;

  // Function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } mspc_state_t;

  typedef struct packed {
    logic load;  // capture the input word
    logic exec;  // apply the item to the motor state
  } mspc_cmd_t;

endpackage

// File: rtl/mspc_ctrl.sv
module mspc_ctrl
  import mspc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output mspc_cmd_t cmd,
  output logic      out_valid
);

  mspc_state_t state_r, state_nxt;
  logic        valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.exec;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = valid_r;

endmodule

// File: rtl/mspc_datapath.sv
module mspc_datapath
  import mspc_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mspc_cmd_t            cmd,
  input  logic                 in_func,
  input  logic [ID_W-1:0]      in_motor_id,
  input  logic [POS_W-1:0]     in_target_pos,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic [MASK_W-1:0]    out_step_pulse_mask,
  output logic [MASK_W-1:0]    out_active_mask,
  output logic [MASK_W-1:0]    out_direction_mask,
  output logic [POS_W-1:0]     out_position_of_addressed,
  output logic [POS_W-1:0]     out_target_of_addressed
);

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int AW    = POS_W + 2;

  logic [POS_W-1:0] limit_r;
  logic [TOL_W-1:0] tol_r;

  logic             func_r;
  logic [ID_W-1:0]  id_r;
  logic [POS_W-1:0] tp_r;

  logic [POS_W-1:0]       pos_r   [MOTOR_COUNT];
  logic [POS_W-1:0]       tgt_r   [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] up_r;
  logic [MOTOR_COUNT-1:0] run_r;

  logic [POS_W-1:0]       pos_nxt [MOTOR_COUNT];
  logic [POS_W-1:0]       tgt_nxt [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] up_nxt;
  logic [MOTOR_COUNT-1:0] run_nxt;

  logic [MASK_W-1:0] pulse_nxt, act_nxt, dir_nxt;
  logic              id_ok;
  logic [IDX_W-1:0]  sel;
  logic signed [AW-1:0] tol_s, lim_s;

  assign id_ok = (32'(id_r) < MOTOR_COUNT);
  assign sel   = IDX_W'(id_r);
  assign tol_s = $signed({{(AW-TOL_W){1'b0}}, tol_r});
  assign lim_s = $signed({2'b00, limit_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= UPPER_LIMIT_RESET;
      tol_r   <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPPER_LIMIT: limit_r <= cfg_wdata[POS_W-1:0];
        CFG_TOLERANCE:   tol_r   <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      id_r   <= in_motor_id;
      tp_r   <= in_target_pos;
    end
  end

  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_motor
    logic signed [AW-1:0] p_step, p_bnd, d_tgt, a_tgt, delta, a_delta;
    logic                 hit_bnd, hit_tgt, is_addr;

    assign is_addr = id_ok && (sel == IDX_W'(m));

    always_comb begin
      p_step  = up_r[m] ? $signed({2'b00, pos_r[m]}) + AW'(1)
                        : $signed({2'b00, pos_r[m]}) - AW'(1);
      // bound is checked only in the direction of travel
      hit_bnd = up_r[m] ? ((lim_s - p_step) < tol_s) : (p_step < tol_s);
      if (hit_bnd) begin
        p_bnd = up_r[m] ? lim_s : '0;
      end else begin
        p_bnd = p_step;
      end
      d_tgt   = p_bnd - $signed({2'b00, tgt_r[m]});
      a_tgt   = (d_tgt < 0) ? -d_tgt : d_tgt;
      hit_tgt = (a_tgt < tol_s);
      delta   = $signed({2'b00, tp_r}) - $signed({2'b00, pos_r[m]});
      a_delta = (delta < 0) ? -delta : delta;

      pos_nxt[m] = pos_r[m];
      tgt_nxt[m] = tgt_r[m];
      up_nxt[m]  = up_r[m];
      run_nxt[m] = run_r[m];
      if (func_r == FUNC_TICK) begin
        if (run_r[m]) begin
          if (hit_tgt) begin
            pos_nxt[m] = tgt_r[m];
          end else begin
            pos_nxt[m] = p_bnd[POS_W-1:0];
          end
          if (hit_bnd || hit_tgt) begin
            run_nxt[m] = 1'b0;
          end
        end
      end else if (is_addr) begin
        if (a_delta < tol_s) begin
          run_nxt[m] = 1'b0;
        end else begin
          tgt_nxt[m] = tp_r;
          run_nxt[m] = 1'b1;
          up_nxt[m]  = (delta >= 0);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r[m] <= '0;
        tgt_r[m] <= '0;
        up_r[m]  <= 1'b1;
        run_r[m] <= 1'b1;
      end else if (cmd.exec) begin
        pos_r[m] <= pos_nxt[m];
        tgt_r[m] <= tgt_nxt[m];
        up_r[m]  <= up_nxt[m];
        run_r[m] <= run_nxt[m];
      end
    end
  end

  // motors past the mask width are not reported
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < MOTOR_COUNT) begin : g_on
      assign pulse_nxt[b] = (func_r == FUNC_TICK) && run_r[b];
      assign act_nxt[b]   = run_nxt[b];
      assign dir_nxt[b]   = up_nxt[b];
    end else begin : g_off
      assign pulse_nxt[b] = 1'b0;
      assign act_nxt[b]   = 1'b0;
      assign dir_nxt[b]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_step_pulse_mask       <= pulse_nxt;
      out_active_mask           <= act_nxt;
      out_direction_mask        <= dir_nxt;
      out_position_of_addressed <= id_ok ? pos_nxt[sel] : '0;
      out_target_of_addressed   <= id_ok ? tgt_nxt[sel] : '0;
    end
  end

endmodule

// File: rtl/multi_stepper_position_controller_top.sv
// Position controller for a bank of stepper motors.
// Input: pulse start with in_func/in_motor_id/in_target_pos while busy is
// low. A tick word (func 0) steps every running motor by one; a set word
// (func 1) loads a new target into the addressed motor.
// Output: one result word per input word, shown for exactly one cycle with
// out_valid high: step pulse, active and direction masks, plus position and
// target of the addressed motor after the update.
// Timing: the execute cycle follows the accepting edge and ends in the
// output register, so the result is shown in the cycle after the execute
// cycle. busy is high during the execute cycle, so a new word is taken
// only once the last one has been executed; the output register frees
// the input side while the result is shown.
// Configuration: cfg_we with cfg_index 0 (upper limit) or 1 (tolerance),
// only while no word is in flight.
// Reset (rst_n low, synchronous): all positions and targets 0, all motors
// running upward, limit 100, tolerance 2. The receiver cannot stall, so
// out_valid is never held.
module multi_stepper_position_controller_top
  import mspc_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [ID_W-1:0]      in_motor_id,
  input  logic [POS_W-1:0]     in_target_pos,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  output logic [MASK_W-1:0]    out_step_pulse_mask,
  output logic [MASK_W-1:0]    out_active_mask,
  output logic [MASK_W-1:0]    out_direction_mask,
  output logic [POS_W-1:0]     out_position_of_addressed,
  output logic [POS_W-1:0]     out_target_of_addressed
);

  mspc_cmd_t cmd;

  mspc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  mspc_datapath #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_datapath (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .in_func                   (in_func),
    .in_motor_id               (in_motor_id),
    .in_target_pos             (in_target_pos),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .out_step_pulse_mask       (out_step_pulse_mask),
    .out_active_mask           (out_active_mask),
    .out_direction_mask        (out_direction_mask),
    .out_position_of_addressed (out_position_of_addressed),
    .out_target_of_addressed   (out_target_of_addressed)
  );

endmodule
